### design/abg_pkg.sv
// shared types, constants and helpers for the multi-track alpha-beta-gamma filter
`default_nettype none
package abg_pkg;
	localparam int TRACKS_DEF = 256;
	localparam int ID_W = 8;
	localparam int POS_W = 32;
	localparam int STAMP_W = 32;
	localparam int GAIN_W = 18;
	localparam int STAT_W = 2;
	localparam int ADDR_W = 4;
	localparam int MUL_W = 34;
	localparam int PROD_W = 68;
	localparam int SUM_W = 70;
	localparam int NUM_W = 65;
	localparam int DEN_W = 62;
	localparam int QUO_W = 41;

	localparam logic [STAT_W-1:0] ST_FIRST = 2'd0;
	localparam logic [STAT_W-1:0] ST_START = 2'd1;
	localparam logic [STAT_W-1:0] ST_FILT = 2'd2;
	localparam logic [STAT_W-1:0] ST_REJ = 2'd3;

	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_BETA = 2'd1;
	localparam logic [1:0] REG_GAMMA = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0] track_id;
		logic signed [POS_W-1:0] meas_x;
		logic signed [POS_W-1:0] meas_y;
		logic [STAMP_W-1:0] stamp;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0] out_track;
		logic signed [POS_W-1:0] filt_x;
		logic signed [POS_W-1:0] filt_y;
		logic [STAT_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(64'sd2147483647);
		lo = SUM_W'(-64'sd2147483648);
		if (x > hi) begin
			return 32'sh7fffffff;
		end else if (x < lo) begin
			return 32'sh80000000;
		end
		return x[POS_W-1:0];
	endfunction

	function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
			input logic signed [PROD_W-1:0] b);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		return sat32(s);
	endfunction

	function automatic logic signed [PROD_W-1:0] rnd_sh(input logic signed [PROD_W-1:0] p,
			input int unsigned k);
		logic signed [PROD_W-1:0] h;
		logic signed [PROD_W-1:0] s;
		h = PROD_W'(1) << (k - 1);
		s = p + h;
		return s >>> k;
	endfunction
endpackage
`default_nettype wire

### design/abg_mul.sv
// shared signed multiplier with registered product
`default_nettype none
module abg_mul (
	input wire logic clk,
	input wire logic signed [abg_pkg::MUL_W-1:0] op_a,
	input wire logic signed [abg_pkg::MUL_W-1:0] op_b,
	output logic signed [abg_pkg::PROD_W-1:0] prod_s1
);
	import abg_pkg::*;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);
	end
endmodule
`default_nettype wire

### design/abg_div.sv
// bit-serial restoring divider with round-to-nearest and quotient clamp
`default_nettype none
module abg_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire abg_pkg::div_req_t req,
	output logic done,
	output logic [abg_pkg::QUO_W-1:0] quo
);
	import abg_pkg::*;

	localparam logic [QUO_W-1:0] QCAP = QUO_W'(1) << (QUO_W - 1);
	localparam logic [6:0] TOP_BIT = 7'(NUM_W - 1);
	localparam logic [6:0] CAP_BIT = 7'(QUO_W - 1);

	logic busy_q, fin_q, done_q, big_q;
	logic [6:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [QUO_W-1:0] q_q, quo_q;
	logic [DEN_W:0] rem_sh, rem_df, half;
	logic ge, up;
	logic [QUO_W:0] qr;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge = rem_sh >= {1'b0, den_q};
		rem_df = rem_sh - {1'b0, den_q};
		half = {1'b0, den_q} - {1'b0, rem_q};
		up = {1'b0, rem_q} >= half;
		qr = {1'b0, q_q} + (QUO_W+1)'(up);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 7'd0) begin
				busy_q <= 1'b0;
				fin_q <= 1'b1;
			end
			if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			q_q <= '0;
			big_q <= 1'b0;
			cnt_q <= TOP_BIT;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? rem_df[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			q_q <= {q_q[QUO_W-2:0], ge};
			if (ge && cnt_q > CAP_BIT) begin
				big_q <= 1'b1;
			end
			cnt_q <= cnt_q - 7'd1;
		end
		if (fin_q) begin
			quo_q <= (big_q || qr > {1'b0, QCAP}) ? QCAP : qr[QUO_W-1:0];
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule
`default_nettype wire

### design/multi_track_abg_filter_unit.sv
// top level: track table, register port and sequencer around the shared multiplier and divider
// usage:
// a measurement word (track, x, y, stamp) is taken at a clock edge with start high and busy
// low; busy then stays high until the result word is out. the result word appears on result
// for exactly one cycle with done high; the receiver cannot hold it off, so it must take it.
// sequence: a first sighting, a start of the filter or a rejected time step passes through
// the read and check states, after the track number is folded into the table by repeated
// subtraction of TRACKS. a filtered word then runs, per axis, ten sequencer steps around the
// shared multiplier, then waits on the first 65-bit serial division and on the second.
// a new word may be started in the cycle that done is high.
// gains are to be written over the apb port only while the block is idle; the block itself
// does not enforce it. reset clears the seen and started flags of every track and loads the
// default gains; the stamp, position, velocity and acceleration tables are not cleared.
`default_nettype none
module multi_track_abg_filter_unit #(
	parameter int TRACKS = abg_pkg::TRACKS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire abg_pkg::item_t item,
	output logic done,
	output abg_pkg::result_t result,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [abg_pkg::ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import abg_pkg::*;

	localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_MOD = 5'd1;
	localparam logic [4:0] S_RD = 5'd2;
	localparam logic [4:0] S_CHK = 5'd3;
	localparam logic [4:0] S_M1 = 5'd4;
	localparam logic [4:0] S_M2 = 5'd5;
	localparam logic [4:0] S_M3 = 5'd6;
	localparam logic [4:0] S_M4 = 5'd7;
	localparam logic [4:0] S_M5 = 5'd8;
	localparam logic [4:0] S_M6 = 5'd9;
	localparam logic [4:0] S_M7 = 5'd10;
	localparam logic [4:0] S_M8 = 5'd11;
	localparam logic [4:0] S_M9 = 5'd12;
	localparam logic [4:0] S_M10 = 5'd13;
	localparam logic [4:0] S_DV = 5'd14;
	localparam logic [4:0] S_DA = 5'd15;
	localparam logic [4:0] S_WB = 5'd16;

	logic [4:0] state_q;
	logic [GAIN_W-1:0] alpha_q, beta_q, gamma_q;
	logic [TRACKS-1:0] seen_q, filt_q;
	item_t item_q;
	logic [ID_W-1:0] id_q;
	logic [TW-1:0] idx;
	logic ax_q;
	logic [STAMP_W-1:0] dt_q;
	logic done_q;
	result_t result_q;

	logic [STAMP_W-1:0] stamp_mem [TRACKS];
	logic [2*POS_W-1:0] pos_mem [TRACKS];
	logic [2*POS_W-1:0] vel_mem [TRACKS];
	logic [2*POS_W-1:0] acc_mem [TRACKS];
	logic [STAMP_W-1:0] stamp_rd_q;
	logic [2*POS_W-1:0] pos_rd_q, vel_rd_q, acc_rd_q;

	logic signed [POS_W-1:0] w_q, v1_q, p1_q;
	logic signed [POS_W:0] r_q;
	logic [POS_W:0] mag_q;
	logic neg_q;
	logic [49:0] gn_q;
	logic [DEN_W-1:0] dd_q;
	logic signed [POS_W-1:0] np_q [2];
	logic signed [POS_W-1:0] nv_q [2];
	logic signed [POS_W-1:0] na_q [2];

	logic signed [MUL_W-1:0] op_a, op_b;
	logic signed [PROD_W-1:0] prod_s1;
	div_req_t dreq;
	logic div_done;
	logic [QUO_W-1:0] quo;

	logic signed [POS_W-1:0] p_cur, v_cur, a_cur, m_cur;
	logic signed [POS_W:0] r_nx;
	logic signed [PROD_W-1:0] q_sgn;
	logic [STAMP_W-1:0] dt_w;
	logic bad_dt, wr_apb;

	assign idx = TW'(id_q);
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;
	assign pready = 1'b1;
	assign wr_apb = psel && penable && pwrite;

	always_comb begin
		p_cur = ax_q ? pos_rd_q[2*POS_W-1:POS_W] : pos_rd_q[POS_W-1:0];
		v_cur = ax_q ? vel_rd_q[2*POS_W-1:POS_W] : vel_rd_q[POS_W-1:0];
		a_cur = ax_q ? acc_rd_q[2*POS_W-1:POS_W] : acc_rd_q[POS_W-1:0];
		m_cur = ax_q ? item_q.meas_y : item_q.meas_x;
		r_nx = (POS_W+1)'(m_cur) - (POS_W+1)'(p1_q);
		q_sgn = $signed({{(PROD_W-QUO_W){1'b0}}, quo});
		if (neg_q) begin
			q_sgn = -q_sgn;
		end
		dt_w = item_q.stamp - stamp_rd_q;
		bad_dt = (dt_w == '0) || dt_w[STAMP_W-1];
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ALPHA: prdata = 32'(alpha_q);
			REG_BETA: prdata = 32'(beta_q);
			REG_GAMMA: prdata = 32'(gamma_q);
			default: prdata = '0;
		endcase
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_M1: begin
				op_a = MUL_W'(a_cur);
				op_b = $signed({2'b0, dt_q});
			end
			S_M3: begin
				op_a = MUL_W'(w_q);
				op_b = $signed({2'b0, dt_q});
			end
			S_M6: begin
				op_a = $signed({{(MUL_W-GAIN_W){1'b0}}, alpha_q});
				op_b = MUL_W'(r_q);
			end
			S_M7: begin
				op_a = $signed({{(MUL_W-GAIN_W){1'b0}}, beta_q});
				op_b = $signed({1'b0, mag_q});
			end
			S_M8: begin
				op_a = $signed({{(MUL_W-GAIN_W){1'b0}}, gamma_q});
				op_b = $signed({1'b0, mag_q});
			end
			S_M9: begin
				op_a = $signed({2'b0, dt_q});
				op_b = $signed({2'b0, dt_q});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = NUM_W'(prod_s1[49:0]);
		dreq.den = DEN_W'(dt_q);
		if (state_q == S_M8) begin
			dreq.start = 1'b1;
		end else if (state_q == S_DV && div_done) begin
			dreq.start = 1'b1;
			dreq.num = {gn_q, 15'd0};
			dreq.den = dd_q;
		end
	end

	abg_mul u_mul (
		.clk(clk),
		.op_a(op_a),
		.op_b(op_b),
		.prod_s1(prod_s1)
	);

	abg_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.done(div_done),
		.quo(quo)
	);

	always_ff @(posedge clk) begin
		stamp_rd_q <= stamp_mem[idx];
		pos_rd_q <= pos_mem[idx];
		vel_rd_q <= vel_mem[idx];
		acc_rd_q <= acc_mem[idx];
		if (state_q == S_CHK) begin
			if (!seen_q[idx]) begin
				stamp_mem[idx] <= item_q.stamp;
			end else if (!bad_dt && !filt_q[idx]) begin
				stamp_mem[idx] <= item_q.stamp;
				pos_mem[idx] <= {item_q.meas_y, item_q.meas_x};
				vel_mem[idx] <= '0;
				acc_mem[idx] <= '0;
			end
		end else if (state_q == S_WB) begin
			stamp_mem[idx] <= item_q.stamp;
			pos_mem[idx] <= {np_q[1], np_q[0]};
			vel_mem[idx] <= {nv_q[1], nv_q[0]};
			acc_mem[idx] <= {na_q[1], na_q[0]};
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= item;
			end
			S_CHK: begin
				dt_q <= dt_w;
			end
			S_M2: begin
				w_q <= sat_add(v_cur, rnd_sh(prod_s1, 17));
				v1_q <= sat_add(v_cur, rnd_sh(prod_s1, 16));
			end
			S_M4: begin
				p1_q <= sat_add(p_cur, rnd_sh(prod_s1, 16));
			end
			S_M5: begin
				r_q <= r_nx;
				neg_q <= r_nx[POS_W];
				mag_q <= r_nx[POS_W] ? (POS_W+1)'(-r_nx) : (POS_W+1)'(r_nx);
			end
			S_M7: begin
				np_q[ax_q] <= sat_add(p1_q, rnd_sh(prod_s1, 16));
			end
			S_M9: begin
				gn_q <= prod_s1[49:0];
			end
			S_M10: begin
				dd_q <= prod_s1[DEN_W-1:0];
			end
			S_DV: begin
				if (div_done) begin
					nv_q[ax_q] <= sat_add(v1_q, q_sgn);
				end
			end
			S_DA: begin
				if (div_done) begin
					na_q[ax_q] <= sat_add(a_cur, q_sgn);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seen_q <= '0;
			filt_q <= '0;
			done_q <= 1'b0;
			ax_q <= 1'b0;
			id_q <= '0;
			alpha_q <= GAIN_W'(65536);
			beta_q <= '0;
			gamma_q <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (wr_apb) begin
				unique case (paddr[3:2])
					REG_ALPHA: alpha_q <= pwdata[GAIN_W-1:0];
					REG_BETA: beta_q <= pwdata[GAIN_W-1:0];
					REG_GAMMA: gamma_q <= pwdata[GAIN_W-1:0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						id_q <= item.track_id;
						ax_q <= 1'b0;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (TRACKS < 256 && 32'(id_q) >= 32'(TRACKS)) begin
						id_q <= id_q - ID_W'(TRACKS);
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					result_q.out_track <= item_q.track_id;
					result_q.filt_x <= item_q.meas_x;
					result_q.filt_y <= item_q.meas_y;
					if (!seen_q[idx]) begin
						seen_q[idx] <= 1'b1;
						result_q.status <= ST_FIRST;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (bad_dt) begin
						result_q.status <= ST_REJ;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (!filt_q[idx]) begin
						filt_q[idx] <= 1'b1;
						result_q.status <= ST_START;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_M5;
				S_M5: state_q <= S_M6;
				S_M6: state_q <= S_M7;
				S_M7: state_q <= S_M8;
				S_M8: state_q <= S_M9;
				S_M9: state_q <= S_M10;
				S_M10: state_q <= S_DV;
				S_DV: begin
					if (div_done) begin
						state_q <= S_DA;
					end
				end
				S_DA: begin
					if (div_done) begin
						if (!ax_q) begin
							ax_q <= 1'b1;
							state_q <= S_M1;
						end else begin
							state_q <= S_WB;
						end
					end
				end
				S_WB: begin
					result_q.out_track <= item_q.track_id;
					result_q.filt_x <= np_q[0];
					result_q.filt_y <= np_q[1];
					result_q.status <= ST_FILT;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
